### rtl/core/s2hsl_pkg.sv
package s2hsl_pkg;

    // Fixed-point format of the incoming scalar: 1 << FRAC_BITS means 1.0
    localparam int FRAC_BITS = 16;
    localparam int SAMPLE_W  = 17;
    localparam int LVL_W     = FRAC_BITS + 1;
    localparam int CMP_W     = (SAMPLE_W > LVL_W) ? SAMPLE_W : LVL_W;
    localparam logic [LVL_W-1:0] LVL_ONE = LVL_W'(1) << FRAC_BITS;

    // Hue arithmetic, degrees
    localparam int HUE_W  = 9;
    localparam int HSUM_W = 10;
    localparam int PROD_W = LVL_W + 9;
    localparam logic [8:0]        DEG_360 = 9'd360;
    localparam logic [HSUM_W-1:0] HUE_BASE  = HSUM_W'(180);
    localparam logic [HSUM_W-1:0] HUE_WRAP  = HSUM_W'(360);
    localparam logic [HSUM_W-1:0] HUE_THIRD = HSUM_W'(120);
    localparam logic [HSUM_W-1:0] HUE_TWO_THIRDS = HSUM_W'(240);
    localparam logic [HUE_W-1:0]  HUE_RAMP_UP   = HUE_W'(60);
    localparam logic [HUE_W-1:0]  HUE_PLATEAU   = HUE_W'(180);
    localparam logic [HUE_W-1:0]  HUE_RAMP_DOWN = HUE_W'(240);

    // Ramp weight 0..60 and the numerator 60*m1 + (m2-m1)*weight
    localparam int WGT_W = 6;
    localparam logic [WGT_W-1:0] WGT_FULL = WGT_W'(60);
    localparam int NUM_W = FRAC_BITS + 6;
    // 255 / 60 = 17 / 4, so channel = (17 * num) >> (FRAC_BITS + 2)
    localparam int SCL_W = NUM_W + 5;
    localparam logic [4:0] SCL_MUL = 5'd17;
    localparam int SCL_SHIFT = FRAC_BITS + 2;

    // Channels
    localparam int CH_W    = 8;
    localparam int NUM_CH  = 3;
    localparam int CH_RED  = 0;
    localparam int CH_GRN  = 1;
    localparam int CH_BLU  = 2;
    localparam logic [CH_W-1:0] CH_MAX = 8'hFF;
    localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;

    // Bus widths
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

endpackage

### rtl/core/scalar_to_hsl_rgba_colormap_unit.sv
// Scalar to RGBA colormap. Each input transfer carries one unsigned fixed-point
// scalar (16 fraction bits, 65536 = 1.0, larger values clip to 1.0) and gives one
// RGBA pixel from an HSL model with full saturation: hue = (180 + floor(360*l))
// mod 360, red/green/blue from the HSL ramp at hue+120, hue and hue-120, alpha
// fixed at 255. Row end (tlast) and frame end (tuser) ride along with the pixel.
// The unit is a five-stage pipeline with no divider: one transfer in per clock
// while the output is not stalled, each stage holding on a stall of its own and
// filling bubbles ahead of a stalled output, so nothing is dropped or repeated.
module scalar_to_hsl_rgba_colormap_unit
    import s2hsl_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // s_tdata: [16:0] sample, rest zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tlast,   // end_of_line
    input  logic                 s_tuser,   // end_of_frame
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // m_tdata: [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast,   // row_done
    output logic                 m_tuser,   // frame_done
    output logic                 m_tvalid,
    input  logic                 m_tready
);

    // Ramp weight for a wrapped hue (0..360): num = 60*m1 + (m2-m1)*weight
    function automatic logic [WGT_W-1:0] ramp_weight(input logic [HUE_W-1:0] h);
        logic [WGT_W-1:0] w;
        if (h < HUE_RAMP_UP) begin
            w = h[WGT_W-1:0];
        end else if (h < HUE_PLATEAU) begin
            w = WGT_FULL;
        end else if (h < HUE_RAMP_DOWN) begin
            w = WGT_W'(HUE_RAMP_DOWN - h);
        end else begin
            w = '0;
        end
        return w;
    endfunction

    // Stage valids and per-stage enables
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    assign en5 = !v5_reg || m_tready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_tready = en1;

    // Payload registers
    logic [PROD_W-1:0] s1_prod_reg, s1_prod_next;
    logic [LVL_W-1:0]  s1_m1_reg, s1_m1_next;
    logic [LVL_W-1:0]  s1_m2_reg, s1_m2_next;
    logic [1:0]        s1_mark_reg;

    logic [HUE_W-1:0]  s2_hue_reg, s2_hue_next;
    logic [LVL_W-1:0]  s2_m1_reg;
    logic [LVL_W-1:0]  s2_diff_reg;
    logic [1:0]        s2_mark_reg;

    logic [WGT_W-1:0]  s3_wgt_reg  [NUM_CH];
    logic [WGT_W-1:0]  s3_wgt_next [NUM_CH];
    logic [LVL_W-1:0]  s3_m1_reg;
    logic [LVL_W-1:0]  s3_diff_reg;
    logic [1:0]        s3_mark_reg;

    logic [NUM_W-1:0]  s4_num_reg  [NUM_CH];
    logic [NUM_W-1:0]  s4_num_next [NUM_CH];
    logic [1:0]        s4_mark_reg;

    logic [CH_W-1:0]   s5_ch_reg   [NUM_CH];
    logic [CH_W-1:0]   s5_ch_next  [NUM_CH];
    logic [1:0]        s5_mark_reg;

    // Stage 1: clip to 1.0, 360*l, lightness split into m1/m2
    logic [LVL_W-1:0] lvl;
    logic [LVL_W:0]   lvl_dbl;
    always_comb begin
        if (CMP_W'(s_tdata[SAMPLE_W-1:0]) > CMP_W'(LVL_ONE)) begin
            lvl = LVL_ONE;
        end else begin
            lvl = LVL_W'(s_tdata[SAMPLE_W-1:0]);
        end
        s1_prod_next = PROD_W'(lvl) * PROD_W'(DEG_360);
        lvl_dbl = {lvl, 1'b0};
        if (lvl_dbl <= (LVL_W+1)'(LVL_ONE)) begin
            s1_m2_next = lvl_dbl[LVL_W-1:0];
            s1_m1_next = '0;
        end else begin
            s1_m2_next = LVL_ONE;
            s1_m1_next = LVL_W'(lvl_dbl - (LVL_W+1)'(LVL_ONE));
        end
    end

    // Stage 2: base hue, mod 360
    logic [HSUM_W-1:0] hue_sum;
    always_comb begin
        hue_sum = HUE_BASE + HSUM_W'(s1_prod_reg[PROD_W-1:FRAC_BITS]);
        if (hue_sum >= HUE_WRAP) begin
            s2_hue_next = HUE_W'(hue_sum - HUE_WRAP);
        end else begin
            s2_hue_next = HUE_W'(hue_sum);
        end
    end

    // Stage 3: channel hues, wrapped, turned into ramp weights
    logic [HSUM_W-1:0] hue_red, hue_blu;
    always_comb begin
        hue_red = HSUM_W'(s2_hue_reg) + HUE_THIRD;
        if (hue_red > HUE_WRAP) begin
            hue_red = hue_red - HUE_WRAP;
        end
        if (HSUM_W'(s2_hue_reg) < HUE_THIRD) begin
            hue_blu = HSUM_W'(s2_hue_reg) + HUE_TWO_THIRDS;
        end else begin
            hue_blu = HSUM_W'(s2_hue_reg) - HUE_THIRD;
        end
        s3_wgt_next[CH_RED] = ramp_weight(hue_red[HUE_W-1:0]);
        s3_wgt_next[CH_GRN] = ramp_weight(s2_hue_reg);
        s3_wgt_next[CH_BLU] = ramp_weight(hue_blu[HUE_W-1:0]);
    end

    // Stage 4: numerator per channel
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            s4_num_next[c] = NUM_W'(s3_m1_reg) * NUM_W'(WGT_FULL)
                           + NUM_W'(s3_diff_reg) * NUM_W'(s3_wgt_reg[c]);
        end
    end

    // Stage 5: scale by 255/60 over 1.0, clip to 8 bits
    logic [SCL_W-1:0] scaled [NUM_CH];
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            scaled[c] = SCL_W'(s4_num_reg[c]) * SCL_W'(SCL_MUL);
            if ((scaled[c] >> SCL_SHIFT) > SCL_W'(CH_MAX)) begin
                s5_ch_next[c] = CH_MAX;
            end else begin
                s5_ch_next[c] = CH_W'(scaled[c] >> SCL_SHIFT);
            end
        end
    end

    // Valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    // Data path
    always_ff @(posedge aclk) begin
        if (en1 && s_tvalid) begin
            s1_prod_reg <= s1_prod_next;
            s1_m1_reg   <= s1_m1_next;
            s1_m2_reg   <= s1_m2_next;
            s1_mark_reg <= {s_tuser, s_tlast};
        end
        if (en2 && v1_reg) begin
            s2_hue_reg  <= s2_hue_next;
            s2_m1_reg   <= s1_m1_reg;
            s2_diff_reg <= s1_m2_reg - s1_m1_reg;
            s2_mark_reg <= s1_mark_reg;
        end
        if (en3 && v2_reg) begin
            s3_wgt_reg  <= s3_wgt_next;
            s3_m1_reg   <= s2_m1_reg;
            s3_diff_reg <= s2_diff_reg;
            s3_mark_reg <= s2_mark_reg;
        end
        if (en4 && v3_reg) begin
            s4_num_reg  <= s4_num_next;
            s4_mark_reg <= s3_mark_reg;
        end
        if (en5 && v4_reg) begin
            s5_ch_reg   <= s5_ch_next;
            s5_mark_reg <= s4_mark_reg;
        end
    end

    assign m_tdata  = {ALPHA_OPAQUE, s5_ch_reg[CH_BLU], s5_ch_reg[CH_GRN], s5_ch_reg[CH_RED]};
    assign m_tlast  = s5_mark_reg[0];
    assign m_tuser  = s5_mark_reg[1];
    assign m_tvalid = v5_reg;

    // An empty output stage never blocks the input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output stage is empty");

    // Base hue is always wrapped below 360
    a_hue_wrapped: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg |-> (s2_hue_reg < HUE_W'(360)))
        else $error("base hue out of range");

    // Ramp weights never pass the full plateau
    a_weight_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg |-> (s3_wgt_reg[CH_RED] <= WGT_FULL && s3_wgt_reg[CH_GRN] <= WGT_FULL
                    && s3_wgt_reg[CH_BLU] <= WGT_FULL))
        else $error("ramp weight out of range");

    // Stage 4, when it holds a stalled item, keeps it
    a_stage4_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && !en4) |=> (v4_reg && $stable(s4_mark_reg)))
        else $error("stalled stage lost its item");

endmodule
